>>> rtl/scl_pkg.sv
package scl_pkg;

    // period field width
    localparam int PERIOD_BITS = 16;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};

    // keyword table size and the keyword that takes digits
    localparam int NUM_KEYS   = 7;
    localparam int KEY_PERIOD = 5;

    // line position counter
    localparam int POS_BITS = 4;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_SCALE  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_PERIOD = 4'd1;

    // line terminator and digit bounds
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // command codes
    typedef enum logic [3:0] {
        CMD_SCALE_F    = 4'd0,
        CMD_SCALE_C    = 4'd1,
        CMD_STOP       = 4'd2,
        CMD_START      = 4'd3,
        CMD_OFF        = 4'd4,
        CMD_PERIOD     = 4'd5,
        CMD_LOG        = 4'd6,
        CMD_INVALID    = 4'd7,
        CMD_BAD_PERIOD = 4'd8
    } cmd_kind_t;

    // classified line handed from front to back
    typedef struct packed {
        cmd_kind_t              kind;
        logic [PERIOD_BITS-1:0] accum;
    } cmd_entry_t;

    // start settings loaded at the first byte
    typedef struct packed {
        logic                   load;
        logic                   scale;
        logic [PERIOD_BITS-1:0] period;
    } start_load_t;

    // keyword text, left justified, one byte per character
    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [2:0] p);
        logic [63:0] word;
        logic [63:0] shifted;
        case (k)
            3'd0:    word = {"SCALE=F", 8'h00};
            3'd1:    word = {"SCALE=C", 8'h00};
            3'd2:    word = {"STOP", 32'h0};
            3'd3:    word = {"START", 24'h0};
            3'd4:    word = {"OFF", 40'h0};
            3'd5:    word = {"PERIOD=", 8'h00};
            3'd6:    word = {"LOG", 40'h0};
            default: word = 64'h0;
        endcase
        shifted = word << {p, 3'b000};
        return shifted[63:56];
    endfunction

    // keyword lengths
    function automatic logic [POS_BITS-1:0] key_len(input logic [2:0] k);
        logic [POS_BITS-1:0] len;
        case (k)
            3'd0:    len = 4'd7;
            3'd1:    len = 4'd7;
            3'd2:    len = 4'd4;
            3'd3:    len = 4'd5;
            3'd4:    len = 4'd3;
            3'd5:    len = 4'd7;
            3'd6:    len = 4'd3;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/scl_front.sv
module scl_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               char_valid,
    input  logic                               char_accept,
    input  logic [7:0]                         char_in,
    input  logic                               cfg_valid,
    input  logic [scl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [scl_pkg::PERIOD_BITS-1:0]    cfg_data,
    output logic                               push,
    output scl_pkg::cmd_entry_t                push_data,
    output scl_pkg::start_load_t               start_load
);
    import scl_pkg::*;

    logic                   start_scale_reg;
    logic [PERIOD_BITS-1:0] start_period_reg;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [NUM_KEYS-1:0]    match_reg, match_next;
    logic                   in_digits_reg, in_digits_next;
    logic [PERIOD_BITS-1:0] accum_reg, accum_next;
    logic                   halted_reg, halted_next;
    logic                   loaded_reg, loaded_next;

    logic                   live;
    logic                   is_newline;
    logic                   is_digit;
    logic [PERIOD_BITS+3:0] accum_wide;
    cmd_kind_t              kind;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_scale_reg  <= 1'b0;
            start_period_reg <= {{(PERIOD_BITS-1){1'b0}}, 1'b1};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_SCALE:  start_scale_reg  <= cfg_data[0];
                CFG_START_PERIOD: start_period_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign live       = char_valid && char_accept && !halted_reg;
    assign is_newline = (char_in == CHAR_NEWLINE);
    assign is_digit   = (char_in inside {[CHAR_ZERO:CHAR_NINE]});

    // accumulate times ten plus digit
    assign accum_wide = {4'b0000, accum_reg} * (PERIOD_BITS+4)'(10)
                        + {{(PERIOD_BITS-4){1'b0}}, char_in[3:0] - CHAR_ZERO[3:0]};

    // line classification, first keyword in table order wins
    always_comb
    begin
        kind = CMD_INVALID;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (match_reg[k] && pos_reg >= key_len(3'(k)))
                kind = cmd_kind_t'(4'(k));
        end
    end

    // per-beat line tracking
    always_comb
    begin
        pos_next       = pos_reg;
        match_next     = match_reg;
        in_digits_next = in_digits_reg;
        accum_next     = accum_reg;
        halted_next    = halted_reg;
        loaded_next    = loaded_reg;
        push           = 1'b0;

        if (live)
        begin
            loaded_next = 1'b1;
            if (!is_newline)
            begin
                if (in_digits_reg)
                begin
                    if (is_digit)
                        accum_next = (accum_wide > {4'b0000, PERIOD_MAX}) ?
                                     PERIOD_MAX : accum_wide[PERIOD_BITS-1:0];
                    else
                        in_digits_next = 1'b0;
                end
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    if (pos_reg < key_len(3'(k)) && key_char(3'(k), pos_reg[2:0]) != char_in)
                        match_next[k] = 1'b0;
                end
                if (pos_reg == POS_BITS'(6) && match_next[KEY_PERIOD])
                    in_digits_next = 1'b1;
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + POS_BITS'(1);
            end
            else
            begin
                push           = (pos_reg != '0);
                if (push && kind == CMD_OFF)
                    halted_next = 1'b1;
                pos_next       = '0;
                match_next     = '1;
                in_digits_next = 1'b0;
                accum_next     = '0;
            end
        end
    end

    assign push_data.kind  = kind;
    assign push_data.accum = accum_reg;

    // start settings go to the back on the first live beat
    assign start_load.load   = live && !loaded_reg;
    assign start_load.scale  = start_scale_reg;
    assign start_load.period = (start_period_reg == '0) ?
                               {{(PERIOD_BITS-1){1'b0}}, 1'b1} : start_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            match_reg     <= '1;
            in_digits_reg <= 1'b0;
            accum_reg     <= '0;
            halted_reg    <= 1'b0;
            loaded_reg    <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            match_reg     <= match_next;
            in_digits_reg <= in_digits_next;
            accum_reg     <= accum_next;
            halted_reg    <= halted_next;
            loaded_reg    <= loaded_next;
        end
    end

endmodule

>>> rtl/scl_queue.sv
module scl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scl_pkg::cmd_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output scl_pkg::cmd_entry_t pop_data,
    output logic                not_empty
);
    import scl_pkg::*;

    cmd_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = ~wr_ptr_reg;
        if (pop)
            rd_ptr_next = ~rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/scl_back.sv
module scl_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  scl_pkg::start_load_t            start_load,
    input  logic                            q_not_empty,
    input  scl_pkg::cmd_entry_t             q_data,
    output logic                            q_pop,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output logic [3:0]                      command_kind,
    output logic                            scale_celsius,
    output logic                            reporting,
    output logic [scl_pkg::PERIOD_BITS-1:0] period_seconds
);
    import scl_pkg::*;

    logic                   scale_reg, scale_next;
    logic                   report_reg, report_next;
    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic                   valid_reg;
    cmd_kind_t              kind_reg, kind_next;

    assign q_pop = q_not_empty && (!valid_reg || cmd_ready);

    // apply the start values and the command to the settings
    always_comb
    begin
        scale_next  = scale_reg;
        report_next = report_reg;
        period_next = period_reg;
        kind_next   = q_data.kind;
        if (start_load.load)
        begin
            scale_next  = start_load.scale;
            period_next = start_load.period;
        end
        case (q_data.kind)
            CMD_SCALE_F: scale_next  = 1'b0;
            CMD_SCALE_C: scale_next  = 1'b1;
            CMD_STOP:    report_next = 1'b0;
            CMD_START:   report_next = 1'b1;
            CMD_PERIOD:
            begin
                if (q_data.accum == '0)
                    kind_next = CMD_BAD_PERIOD;
                else
                    period_next = q_data.accum;
            end
            default:     ;
        endcase
    end

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= 1'b0;
            report_reg <= 1'b1;
            period_reg <= {{(PERIOD_BITS-1){1'b0}}, 1'b1};
        end
        else if (q_pop)
        begin
            scale_reg  <= scale_next;
            report_reg <= report_next;
            period_reg <= period_next;
        end
        else if (start_load.load)
        begin
            scale_reg  <= start_load.scale;
            period_reg <= start_load.period;
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (cmd_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            kind_reg <= kind_next;
    end

    assign cmd_valid      = valid_reg;
    assign command_kind   = kind_reg;
    assign scale_celsius  = scale_reg;
    assign reporting      = report_reg;
    assign period_seconds = period_reg;

endmodule

>>> rtl/sensor_command_line_parser.sv
// sensor command line parser
// char channel: char_valid/char_ready carry one byte of the command stream per
//   beat on char_in; byte 10 ends a line, empty lines give nothing
// cmd channel: cmd_valid/cmd_ready carry one result per non-empty line:
//   command_kind plus scale_celsius, reporting and period_seconds as they
//   stand after the command
// cfg channel: cfg_valid/cfg_ready write start_scale_celsius (index 0) and
//   start_period (index 1); always ready; the user must write them only while
//   idle, the block itself does not enforce it
// throughput: one byte per cycle while char_ready is high; the front tracks
//   keyword matches and digits in one step per byte, the back applies one
//   command per cycle while cmd_ready is high or the output is empty
// path: a result goes through the two-entry queue, then the output register
// reset: settings go to Fahrenheit, reporting on, period 1; the start values
//   are taken from the registers at the first byte; after an OFF line every
//   byte is taken and dropped until reset
// stall: while cmd_ready is low the output beat holds, the queue fills with up
//   to two lines and then char_ready drops
module sensor_command_line_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               char_valid,
    output logic                               char_ready,
    input  logic [7:0]                         char_in,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [scl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [scl_pkg::PERIOD_BITS-1:0]    cfg_data,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output logic [3:0]                         command_kind,
    output logic                               scale_celsius,
    output logic                               reporting,
    output logic [scl_pkg::PERIOD_BITS-1:0]    period_seconds
);
    import scl_pkg::*;

    logic        q_full;
    logic        q_not_empty;
    logic        q_push;
    logic        q_pop;
    cmd_entry_t  q_in;
    cmd_entry_t  q_out;
    start_load_t start_load;

    assign cfg_ready  = 1'b1;
    assign char_ready = !q_full;

    // front: byte tracking and line classification
    scl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_accept (char_ready),
        .char_in     (char_in),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (q_push),
        .push_data   (q_in),
        .start_load  (start_load)
    );

    // queue between front and back
    scl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    // back: settings update and result beat
    scl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .start_load     (start_load),
        .q_not_empty    (q_not_empty),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .command_kind   (command_kind),
        .scale_celsius  (scale_celsius),
        .reporting      (reporting),
        .period_seconds (period_seconds)
    );

`ifndef ASSERT_OFF
    // a stop result always shows reporting off
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && command_kind == CMD_STOP |-> !reporting)
        else $error("stop result with reporting on");

    // a start result always shows reporting on
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && command_kind == CMD_START |-> reporting)
        else $error("start result with reporting off");

    // a celsius result always shows the celsius scale
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && command_kind == CMD_SCALE_C |-> scale_celsius)
        else $error("scale_c result with fahrenheit scale");

    // the period never reads zero on a result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> period_seconds != '0)
        else $error("zero period on result");
`endif

endmodule
